// ===== design/terminal_line_model_with_scrollback_defines.svh =====
// Shared assertion macros for the terminal line model.
`ifndef TERMINAL_LINE_MODEL_WITH_SCROLLBACK_DEFINES_SVH
`define TERMINAL_LINE_MODEL_WITH_SCROLLBACK_DEFINES_SVH

// Implication checked in the cycle after the antecedent, off while reset is high.
`define TLM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tlm assertion failed");

// Same-cycle implication, off while reset is high.
`define TLM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlm assertion failed");

// Implication checked in the cycle after the antecedent, active during reset too.
`define TLM_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tlm assertion failed");

`endif

// ===== design/tlm_pkg.sv =====
package tlm_pkg;

   localparam int RING_LINES_DEF = 256;
   localparam int LINE_COLS_DEF  = 512;
   localparam int OUT_LEN_W      = 9;
   localparam int Q_DEPTH        = 2;

   localparam logic [7:0] CH_ESC = 8'h1b;
   localparam logic [7:0] CH_DEL = 8'h7f;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CSI_LO = 8'h40;
   localparam logic [7:0] CSI_HI = 8'h7e;
   localparam logic [7:0] CH_K   = 8'h4b;
   localparam logic [7:0] CH_LBR = 8'h5b;

   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_CSI    = 2'd2;

   localparam logic ACT_FEED = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUT,
      OP_TAB,
      OP_CR,
      OP_BS,
      OP_TRUNC,
      OP_LF,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic [7:0] line_index;
      logic [8:0] column;
      logic [1:0] phase;
   } item_type;

endpackage

// ===== design/tlm_ram.sv =====
module tlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tlm_front.sv =====
module tlm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [7:0]         req_data_byte,
   input  logic [7:0]         req_line_index,
   input  logic [8:0]         req_column,
   input  logic               q_full,
   output logic               q_push,
   output tlm_pkg::item_type  q_item
);

   logic [1:0]      phase_ff;
   logic [1:0]      phase_in;
   tlm_pkg::op_type op;

   always_comb begin
      phase_in = phase_ff;
      op       = tlm_pkg::OP_NOP;
      if (req_action == tlm_pkg::ACT_READ) begin
         op = tlm_pkg::OP_READ;
      end else if (phase_ff == tlm_pkg::PH_ESC) begin
         phase_in = (req_data_byte == tlm_pkg::CH_LBR) ? tlm_pkg::PH_CSI : tlm_pkg::PH_NORMAL;
      end else if (phase_ff == tlm_pkg::PH_CSI) begin
         if (req_data_byte >= tlm_pkg::CSI_LO && req_data_byte <= tlm_pkg::CSI_HI) begin
            phase_in = tlm_pkg::PH_NORMAL;
            if (req_data_byte == tlm_pkg::CH_K) begin
               op = tlm_pkg::OP_TRUNC;
            end
         end
      end else begin
         unique case (req_data_byte) inside
            tlm_pkg::CH_ESC: phase_in = tlm_pkg::PH_ESC;
            tlm_pkg::CH_LF:  op = tlm_pkg::OP_LF;
            tlm_pkg::CH_CR:  op = tlm_pkg::OP_CR;
            tlm_pkg::CH_BS,
            tlm_pkg::CH_DEL: op = tlm_pkg::OP_BS;
            tlm_pkg::CH_TAB: op = tlm_pkg::OP_TAB;
            tlm_pkg::CH_BEL: op = tlm_pkg::OP_NOP;
            default: begin
               op = (req_data_byte >= tlm_pkg::CH_SP) ? tlm_pkg::OP_PUT : tlm_pkg::OP_NOP;
            end
         endcase
      end
   end

   assign req_ready         = !q_full;
   assign q_push            = req_valid && !q_full;
   assign q_item.op         = op;
   assign q_item.data_byte  = req_data_byte;
   assign q_item.line_index = req_line_index;
   assign q_item.column     = req_column;
   assign q_item.phase      = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tlm_pkg::PH_NORMAL;
      end else if (q_push) begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ===== design/tlm_queue.sv =====
module tlm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tlm_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output tlm_pkg::item_type pop_item
);

   localparam int PW = $clog2(tlm_pkg::Q_DEPTH);
   localparam int CW = $clog2(tlm_pkg::Q_DEPTH + 1);

   tlm_pkg::item_type slot_ff [tlm_pkg::Q_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;

   assign full     = (count_ff == CW'(tlm_pkg::Q_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(tlm_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(tlm_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/tlm_back.sv =====
module tlm_back #(
   parameter int RING_LINES = tlm_pkg::RING_LINES_DEF,
   parameter int LINE_COLS  = tlm_pkg::LINE_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  tlm_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_char,
   output logic [8:0]        rsp_read_length,
   output logic [8:0]        rsp_cursor_column,
   output logic [8:0]        rsp_live_length,
   output logic [8:0]        rsp_stored_lines,
   output logic              rsp_line_pushed,
   output logic [1:0]        rsp_escape_phase
);

   localparam int CW   = $clog2(LINE_COLS);
   localparam int SW   = $clog2(RING_LINES + 1);
   localparam int SUMW = ((SW > 8) ? SW : 8) + 1;
   localparam int OW   = tlm_pkg::OUT_LEN_W;
   localparam logic [CW-1:0] LAST_COL = CW'(LINE_COLS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   tlm_pkg::op_type op_ff;
   logic [7:0]      byte_ff;
   logic [8:0]      col_ff;
   logic [1:0]      phase_ff;
   logic            hit_ff, hit_in;
   logic            pushed_ff;
   logic [7:0]      rchar_ff, rchar_in;
   logic [CW-1:0]   rlen_ff, rlen_in;
   logic [CW-1:0]   cursor_ff, cursor_in;
   logic [CW-1:0]   len_ff, len_in;
   logic [SW-1:0]   oldest_ff, oldest_in;
   logic [SW-1:0]   head_ff, head_in;
   logic [SW-1:0]   count_ff, count_in;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_char_ff;
   logic [OW-1:0]   rsp_rlen_ff, rsp_cursor_ff, rsp_len_ff, rsp_count_ff;
   logic            rsp_pushed_ff;
   logic [1:0]      rsp_phase_ff;

   logic [SUMW-1:0] slot_sum;
   logic [SW-1:0]   rd_slot;
   logic            rd_en;
   logic            txt_we, len_we;
   logic [7:0]      txt_wdata;
   logic [7:0]      txt_rdata;
   logic [CW-1:0]   len_rdata;
   logic [CW-1:0]   next_col;
   logic            load_out;

   assign slot_sum = SUMW'(oldest_ff) + SUMW'(q_item.line_index);
   assign rd_slot  = (slot_sum >= SUMW'(RING_LINES + 1)) ?
                     SW'(slot_sum - SUMW'(RING_LINES + 1)) : SW'(slot_sum);
   assign hit_in   = SUMW'(q_item.line_index) < SUMW'(count_ff);
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign rd_en    = q_pop && (q_item.op == tlm_pkg::OP_READ);
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign next_col = cursor_ff + 1'b1;

   tlm_ram #(.WIDTH(8), .DEPTH((RING_LINES + 1) * (2 ** CW))) u_text (
      .clock   (clock),
      .wr_en   (txt_we),
      .wr_addr ({head_ff, cursor_ff}),
      .wr_data (txt_wdata),
      .rd_en   (rd_en),
      .rd_addr ({rd_slot, CW'(q_item.column)}),
      .rd_data (txt_rdata)
   );

   tlm_ram #(.WIDTH(CW), .DEPTH(RING_LINES + 1)) u_lengths (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (head_ff),
      .wr_data (len_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_slot),
      .rd_data (len_rdata)
   );

   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      len_in    = len_ff;
      oldest_in = oldest_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      rchar_in  = rchar_ff;
      rlen_in   = rlen_ff;
      txt_we    = 1'b0;
      txt_wdata = byte_ff;
      len_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               rchar_in = '0;
               rlen_in  = '0;
               state_in = (q_item.op == tlm_pkg::OP_READ) ? ST_READ : ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            case (op_ff) inside
               tlm_pkg::OP_PUT, tlm_pkg::OP_TAB: begin
                  if (op_ff == tlm_pkg::OP_TAB) begin
                     txt_wdata = tlm_pkg::CH_SP;
                  end
                  if (cursor_ff < LAST_COL) begin
                     txt_we    = 1'b1;
                     cursor_in = next_col;
                     if (next_col > len_ff) begin
                        len_in = next_col;
                     end
                     if (op_ff == tlm_pkg::OP_TAB && next_col[1:0] != 2'b00
                         && next_col < LAST_COL) begin
                        state_in = ST_EXEC;
                     end
                  end
               end
               tlm_pkg::OP_CR: cursor_in = '0;
               tlm_pkg::OP_BS: begin
                  if (cursor_ff != '0) begin
                     cursor_in = cursor_ff - 1'b1;
                  end
               end
               tlm_pkg::OP_TRUNC: len_in = cursor_ff;
               tlm_pkg::OP_LF: begin
                  len_we    = 1'b1;
                  head_in   = (head_ff == SW'(RING_LINES)) ? '0 : head_ff + 1'b1;
                  if (count_ff < SW'(RING_LINES)) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     oldest_in = (oldest_ff == SW'(RING_LINES)) ? '0 : oldest_ff + 1'b1;
                  end
                  len_in    = '0;
                  cursor_in = '0;
               end
               default: ;
            endcase
         end
         ST_READ: begin
            state_in = ST_OUT;
            if (hit_ff) begin
               rlen_in = len_rdata;
               if (int'(col_ff) < int'(len_rdata) && int'(col_ff) < LINE_COLS) begin
                  rchar_in = txt_rdata;
               end
            end
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff     <= q_item.op;
         byte_ff   <= q_item.data_byte;
         col_ff    <= q_item.column;
         phase_ff  <= q_item.phase;
         hit_ff    <= hit_in;
         pushed_ff <= (q_item.op == tlm_pkg::OP_LF);
      end
      rchar_ff <= rchar_in;
      rlen_ff  <= rlen_in;
      if (load_out) begin
         rsp_char_ff   <= rchar_ff;
         rsp_rlen_ff   <= OW'(rlen_ff);
         rsp_cursor_ff <= OW'(cursor_ff);
         rsp_len_ff    <= OW'(len_ff);
         rsp_count_ff  <= OW'(count_ff);
         rsp_pushed_ff <= pushed_ff;
         rsp_phase_ff  <= phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         len_ff       <= '0;
         oldest_ff    <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         len_ff    <= len_in;
         oldest_ff <= oldest_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_char     = rsp_char_ff;
   assign rsp_read_length   = rsp_rlen_ff;
   assign rsp_cursor_column = rsp_cursor_ff;
   assign rsp_live_length   = rsp_len_ff;
   assign rsp_stored_lines  = rsp_count_ff;
   assign rsp_line_pushed   = rsp_pushed_ff;
   assign rsp_escape_phase  = rsp_phase_ff;

endmodule

// ===== design/terminal_line_model_with_scrollback.sv =====
// Terminal line model with scrollback.
// Request channel (req_): action 0 feeds one terminal byte into the live line,
// action 1 reads one byte of a stored line (line_index 0 is the oldest).
// Response channel (rsp_): one transfer per request, in order, carrying the read
// byte and length plus cursor, live length, stored line count, push flag and
// escape phase as they stand after the request.
// A front end decodes bytes and tracks the escape phase; a two-entry queue
// feeds the back end, which owns the line state and the text and length RAMs.
// The live line is written straight into the ring slot that LF commits, so a
// line feed takes no copy.
// A request goes through the queue, then the back-end states idle, execute
// (read for a read) and output; a tab repeats execute while it writes its n
// spaces (n up to 4). The back end pops a request only after the last is loaded.
// Reset empties the ring, homes the cursor and clears the queue and the
// response register; no clearing pass is needed. A stalled response holds in
// its register while up to two more requests are taken into the queue.
module terminal_line_model_with_scrollback #(
   parameter int RING_LINES = tlm_pkg::RING_LINES_DEF,
   parameter int LINE_COLS  = tlm_pkg::LINE_COLS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_line_index,
   input  logic [8:0] req_column,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_char,
   output logic [8:0] rsp_read_length,
   output logic [8:0] rsp_cursor_column,
   output logic [8:0] rsp_live_length,
   output logic [8:0] rsp_stored_lines,
   output logic       rsp_line_pushed,
   output logic [1:0] rsp_escape_phase
);

   tlm_pkg::item_type push_item, pop_item;
   logic              q_push, q_full, q_pop, q_valid;

   tlm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_line_index (req_line_index),
      .req_column     (req_column),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   tlm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   tlm_back #(.RING_LINES(RING_LINES), .LINE_COLS(LINE_COLS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (pop_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_length   (rsp_read_length),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_live_length   (rsp_live_length),
      .rsp_stored_lines  (rsp_stored_lines),
      .rsp_line_pushed   (rsp_line_pushed),
      .rsp_escape_phase  (rsp_escape_phase)
   );

endmodule

// ===== design/tlm_checker.sv =====
`include "terminal_line_model_with_scrollback_defines.svh"

module tlm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_action,
   input logic [7:0] req_data_byte,
   input logic [7:0] req_line_index,
   input logic [8:0] req_column,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_char,
   input logic [8:0] rsp_read_length,
   input logic [8:0] rsp_cursor_column,
   input logic [8:0] rsp_live_length,
   input logic [8:0] rsp_stored_lines,
   input logic       rsp_line_pushed,
   input logic [1:0] rsp_escape_phase
);

   logic line_cleared;

   assign line_cleared = rsp_live_length == 9'd0 && rsp_cursor_column == 9'd0
                         && rsp_stored_lines != 9'd0;

   `TLM_ASSERT_ALWAYS(a_reset_clears_rsp, reset, !rsp_valid)
   `TLM_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)
   `TLM_ASSERT_NOW(a_push_empties_line, rsp_valid && rsp_line_pushed, line_cleared)
   `TLM_ASSERT_NOW(a_cursor_in_line, rsp_valid, rsp_cursor_column <= rsp_live_length)
   `TLM_ASSERT_NOW(a_read_char_in_line, rsp_valid && rsp_read_char != 8'd0, rsp_read_length != 9'd0 && !rsp_line_pushed)

endmodule

bind terminal_line_model_with_scrollback tlm_checker u_tlm_checker (.*);
